>>> hdl/sbca_pkg.sv
// Package for the segregated bitmap chunk allocator.
// Holds pool sizes, widths, status and state codes and the pool configuration struct.
// No dependencies.
package sbca_pkg;

  localparam int SMALL_CHUNKS  = 1024;
  localparam int MEDIUM_CHUNKS = 512;
  localparam int LARGE_CHUNKS  = 512;

  // All three bitmaps share one memory, laid out small, medium, large.
  localparam int MAP_DEPTH  = SMALL_CHUNKS + MEDIUM_CHUNKS + LARGE_CHUNKS;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int SMALL_OFF  = 0;
  localparam int MEDIUM_OFF = SMALL_CHUNKS;
  localparam int LARGE_OFF  = SMALL_CHUNKS + MEDIUM_CHUNKS;

  localparam int LIM_W  = 11;
  localparam int NEED_W = 11;
  localparam int IDX_W  = 16;
  localparam int MASK_W = 16;
  localparam int ADR_W  = 34;
  localparam int SIZE_W = 17;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_SMALL_BASE   = 3'd0,
    CFG_MEDIUM_BASE  = 3'd1,
    CFG_LARGE_BASE   = 3'd2,
    CFG_SMALL_COUNT  = 3'd3,
    CFG_MEDIUM_COUNT = 3'd4,
    CFG_LARGE_COUNT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_CHK,
    S_ALIGN,
    S_ALIGN_IDX,
    S_FS_ISSUE,
    S_FS_WAIT,
    S_RUN_ISSUE,
    S_RUN_WAIT,
    S_MARK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [31:0]      small_base;
    logic [31:0]      medium_base;
    logic [31:0]      large_base;
    logic [LIM_W-1:0] small_lim;
    logic [LIM_W-1:0] medium_lim;
    logic [LIM_W-1:0] large_lim;
  } pool_cfg_t;

endpackage

>>> hdl/sbca_ifs.sv
// Valid/ready channel interfaces for the allocator's request and response.
// Depends on sbca_pkg for the status type and field widths.
interface sbca_req_if;
  import sbca_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] req_size;
  logic [3:0]        align_log2;
  logic [31:0]       block_address;
  modport source (output valid, func, req_size, align_log2, block_address, input ready);
  modport sink   (input valid, func, req_size, align_log2, block_address, output ready);
endinterface

interface sbca_rsp_if;
  import sbca_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] granted_address;
  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

>>> hdl/sbca_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module sbca_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end
endmodule

>>> hdl/sbca_cfg.sv
// Pool configuration registers and the usable chunk limit of each pool.
// Depends on sbca_pkg.
module sbca_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output sbca_pkg::pool_cfg_t pool_cfg
);
  import sbca_pkg::*;

  logic [31:0] small_base, medium_base, large_base;
  logic [10:0] small_count;
  logic [9:0]  medium_count, large_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_base   <= '0;
      medium_base  <= '0;
      large_base   <= '0;
      small_count  <= '0;
      medium_count <= '0;
      large_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SMALL_BASE:   small_base   <= cfg_data;
        CFG_MEDIUM_BASE:  medium_base  <= cfg_data;
        CFG_LARGE_BASE:   large_base   <= cfg_data;
        CFG_SMALL_COUNT:  small_count  <= cfg_data[10:0];
        CFG_MEDIUM_COUNT: medium_count <= cfg_data[9:0];
        CFG_LARGE_COUNT:  large_count  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // A pool never uses more chunks than its bitmap holds.
  always_comb begin
    pool_cfg.small_base  = small_base;
    pool_cfg.medium_base = medium_base;
    pool_cfg.large_base  = large_base;
    pool_cfg.small_lim   = (32'(small_count) < 32'(SMALL_CHUNKS)) ?
                           LIM_W'(small_count) : LIM_W'(SMALL_CHUNKS);
    pool_cfg.medium_lim  = (32'(medium_count) < 32'(MEDIUM_CHUNKS)) ?
                           LIM_W'(medium_count) : LIM_W'(MEDIUM_CHUNKS);
    pool_cfg.large_lim   = (32'(large_count) < 32'(LARGE_CHUNKS)) ?
                           LIM_W'(large_count) : LIM_W'(LARGE_CHUNKS);
  end
endmodule

>>> hdl/segregated_bitmap_chunk_allocator_unit.sv
// Top level of the segregated bitmap chunk allocator: sequencer and response register.
// Depends on sbca_pkg, sbca_ifs, sbca_ram and sbca_cfg.
//
// Usage: requests arrive on req (valid/ready), one response per request leaves on rsp.
// The pool is picked by req_size: 128 bytes or more large, 64 or more medium, else small.
// An allocate scans the pool's used bitmap one candidate start at a time through a
// single two-read-port bitmap memory; a free clears the header chunk and the run.
// A zero size is answered as invalid without touching the bitmap; a free is checked
// against the pool's limits and either rejected or cleared. An allocate rounds the start
// address up to the alignment, probes candidate starts (chunk 0 is skipped), reads each
// chunk of the run and then marks the header chunk and the run; a run cut short by a used
// chunk or by the pool end aligns again from where it stopped.
// Each sequencer step makes at most one bitmap memory access.
// The block takes one request at a time: req.ready is high only when the sequencer idles.
// After reset the bitmap memory is cleared by a pass over all MAP_DEPTH (2048) entries
// during which no request is taken; configuration writes on cfg_we are taken at any time.
// When rsp is stalled the finished response waits in its register, and the block can
// accept the next request; that request's response waits until the register frees.
module segregated_bitmap_chunk_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  sbca_req_if.sink    req,
  sbca_rsp_if.source  rsp
);
  import sbca_pkg::*;

  pool_cfg_t pool_cfg;

  sbca_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pool_cfg  (pool_cfg)
  );

  logic              ram_we, ram_wdata, rd0, rd1;
  logic [MAP_AW-1:0] ram_waddr, raddr0, raddr1;

  sbca_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  state_t             state, state_next;
  logic [MAP_AW-1:0]  clr_cnt, clr_cnt_next;
  logic               func, func_next;
  logic [NEED_W-1:0]  need, need_next, n, n_next, k, k_next;
  logic [MASK_W-1:0]  amask, amask_next, step, step_next;
  logic [31:0]        base, base_next, baddr, baddr_next;
  logic [LIM_W-1:0]   lim, lim_next;
  logic [2:0]         cs, cs_next;
  logic [MAP_AW-1:0]  off, off_next;
  logic [IDX_W-1:0]   idx, idx_next, pos, pos_next;
  logic [ADR_W-1:0]   acc, acc_next;
  status_t            res_status, res_status_next;
  logic [31:0]        res_addr, res_addr_next;
  logic               rsp_valid, rsp_valid_next;
  status_t            rsp_status, rsp_status_next;
  logic [31:0]        rsp_addr, rsp_addr_next;

  // Request decode terms.
  logic [2:0]        in_cs;
  logic [MASK_W-1:0] in_align, in_chunk;
  logic [17:0]       in_round;
  // Sequencer arithmetic.
  logic [ADR_W-1:0]  cur_addr;
  logic [IDX_W-1:0]  run_idx;
  logic [31:0]       fdiff, fpos;

  always_comb begin
    if (req.req_size >= SIZE_W'(128)) begin
      in_cs = 3'd7;
    end else if (req.req_size >= SIZE_W'(64)) begin
      in_cs = 3'd6;
    end else begin
      in_cs = 3'd5;
    end
    in_align = MASK_W'(1) << req.align_log2;
    in_chunk = MASK_W'(1) << in_cs;
    in_round = {1'b0, req.req_size} + 18'((in_chunk - MASK_W'(1)));
    cur_addr = ADR_W'(base) + (ADR_W'(pos) << cs);
    run_idx  = pos + IDX_W'(n);
    fdiff    = baddr - base;
    fpos     = fdiff >> cs;
  end

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    func_next       = func;
    need_next       = need;
    n_next          = n;
    k_next          = k;
    amask_next      = amask;
    step_next       = step;
    base_next       = base;
    baddr_next      = baddr;
    lim_next        = lim;
    cs_next         = cs;
    off_next        = off;
    idx_next        = idx;
    pos_next        = pos;
    acc_next        = acc;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_addr_next   = rsp_addr;
    ram_we          = 1'b0;
    ram_waddr       = MAP_AW'(off + MAP_AW'(pos) - MAP_AW'(1) + MAP_AW'(k));
    ram_wdata       = 1'b0;
    raddr0          = MAP_AW'(off + MAP_AW'(idx));
    raddr1          = MAP_AW'(off + MAP_AW'(idx) - MAP_AW'(1));

    unique case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_cnt;
        clr_cnt_next = clr_cnt + MAP_AW'(1);
        if (32'(clr_cnt) == 32'(MAP_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          func_next  = req.func;
          baddr_next = req.block_address;
          cs_next    = in_cs;
          need_next  = NEED_W'(in_round >> in_cs);
          amask_next = in_align - MASK_W'(1);
          step_next  = (in_align > in_chunk) ? (in_align >> in_cs) : MASK_W'(1);
          pos_next   = '0;
          unique case (in_cs)
            3'd7: begin
              base_next = pool_cfg.large_base;
              lim_next  = pool_cfg.large_lim;
              off_next  = MAP_AW'(LARGE_OFF);
            end
            3'd6: begin
              base_next = pool_cfg.medium_base;
              lim_next  = pool_cfg.medium_lim;
              off_next  = MAP_AW'(MEDIUM_OFF);
            end
            default: begin
              base_next = pool_cfg.small_base;
              lim_next  = pool_cfg.small_lim;
              off_next  = MAP_AW'(SMALL_OFF);
            end
          endcase
          res_addr_next = '0;
          if (req.req_size == '0) begin
            res_status_next = ST_INVALID;
            state_next      = S_RESP;
          end else if (req.func) begin
            state_next = S_FREE_CHK;
          end else begin
            state_next = S_ALIGN;
          end
        end
      end
      S_FREE_CHK: begin
        if (baddr < base || fpos == '0 || fpos >= 32'(lim) ||
            fpos + 32'(need) > 32'(lim)) begin
          res_status_next = ST_INVALID;
          state_next      = S_RESP;
        end else begin
          pos_next   = IDX_W'(fpos);
          k_next     = '0;
          state_next = S_MARK;
        end
      end
      S_ALIGN: begin
        if ((cur_addr & ADR_W'(amask)) != '0) begin
          acc_next   = (cur_addr + ADR_W'(amask)) & ~ADR_W'(amask);
          state_next = S_ALIGN_IDX;
        end else begin
          idx_next   = pos;
          state_next = S_FS_ISSUE;
        end
      end
      S_ALIGN_IDX: begin
        idx_next   = IDX_W'((acc - ADR_W'(base)) >> cs);
        state_next = S_FS_ISSUE;
      end
      S_FS_ISSUE: begin
        if (idx >= IDX_W'(lim)) begin
          res_status_next = ST_NOSPACE;
          state_next      = S_RESP;
        end else if (idx == '0) begin
          idx_next = idx + step;
        end else begin
          state_next = S_FS_WAIT;
        end
      end
      S_FS_WAIT: begin
        if (!rd0 && !rd1) begin
          pos_next   = idx;
          n_next     = '0;
          state_next = S_RUN_ISSUE;
        end else begin
          idx_next   = idx + step;
          state_next = S_FS_ISSUE;
        end
      end
      S_RUN_ISSUE: begin
        raddr0 = MAP_AW'(off + MAP_AW'(run_idx));
        if (run_idx < IDX_W'(lim) && n < need) begin
          state_next = S_RUN_WAIT;
        end else if (n == need) begin
          k_next     = '0;
          state_next = S_MARK;
        end else begin
          pos_next   = run_idx;
          state_next = S_ALIGN;
        end
      end
      S_RUN_WAIT: begin
        if (!rd0) begin
          n_next     = n + NEED_W'(1);
          state_next = S_RUN_ISSUE;
        end else begin
          // The run is too short: skip past it and align again.
          pos_next   = run_idx;
          state_next = S_ALIGN;
        end
      end
      S_MARK: begin
        // Writes the header chunk first, then the run; free clears the same bits.
        ram_we    = 1'b1;
        ram_wdata = !func;
        k_next    = k + NEED_W'(1);
        if (k == need) begin
          res_status_next = ST_OK;
          res_addr_next   = func ? 32'd0 : cur_addr[31:0];
          state_next      = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_addr_next   = res_addr;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
    func       <= func_next;
    need       <= need_next;
    n          <= n_next;
    k          <= k_next;
    amask      <= amask_next;
    step       <= step_next;
    base       <= base_next;
    baddr      <= baddr_next;
    lim        <= lim_next;
    cs         <= cs_next;
    off        <= off_next;
    idx        <= idx_next;
    pos        <= pos_next;
    acc        <= acc_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    rsp_status <= rsp_status_next;
    rsp_addr   <= rsp_addr_next;
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.granted_address = rsp_addr;

  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_RESP))
    else $error("response raised outside the response step");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during the clearing pass");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.granted_address == 32'd0))
    else $error("nonzero address on a failed request");

  a_mark_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (pos != '0 && pos < IDX_W'(lim)))
    else $error("mark outside the usable pool");
endmodule
